/* hdl/stb_pkg.sv */
// shared types and constants for the software timer bank
`default_nettype none
package stb_pkg;

	localparam int NUM_TIMERS = 8;
	localparam int AW         = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
	localparam int IDX_W      = 3;
	localparam int VAL_W      = 16;
	localparam int MASK_W     = 8;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_START = 2'd1,
		CMD_STOP  = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_MOD
	} state_t;

	typedef struct packed {
		logic             en;
		logic [VAL_W-1:0] limit;
		logic [VAL_W-1:0] count;
		logic [VAL_W-1:0] total;
	} entry_t;

	typedef struct packed {
		logic          we;
		logic [AW-1:0] waddr;
		entry_t        wdata;
		logic          re;
		logic [AW-1:0] raddr;
	} mem_req_t;

endpackage
`default_nettype wire

/* hdl/stb_store.sv */
// timer entry memory with per-entry valid bits and registered read
`default_nettype none
module stb_store (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire stb_pkg::mem_req_t req,
	output stb_pkg::entry_t        rdata
);

	stb_pkg::entry_t                    mem [stb_pkg::NUM_TIMERS];
	stb_pkg::entry_t                    rd_q;
	logic                               rvld_q;
	logic [stb_pkg::NUM_TIMERS-1:0]     vld_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_q <= mem[req.raddr];
		end
	end

	// an entry never written reads as all zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (req.we) begin
				vld_q[req.waddr] <= 1'b1;
			end
			if (req.re) begin
				rvld_q <= vld_q[req.raddr];
			end
		end
	end

	assign rdata = rvld_q ? rd_q : '0;

endmodule
`default_nettype wire

/* hdl/software_timer_bank_top.sv */
// top level of the software timer bank: command sequencer and entry update
`default_nettype none
// A command is taken when start is high and busy is low, and its result appears
// on the report ports for exactly one cycle with done high; the receiver cannot
// stall it. Timer entries live in one memory with a single read and a single
// write port, read-modify-written one entry per cycle. Start, stop and read
// step through the ISSUE and MOD states before done; tick stays in MOD while
// it sweeps every timer. busy drops in the cycle that done is shown, so the
// next command can be accepted then. Reset clears the bank at once through
// per-entry valid bits; there is no clearing pass.
module software_timer_bank_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [1:0]                    command,
	input  wire logic [stb_pkg::IDX_W-1:0]     timer_index,
	input  wire logic [stb_pkg::VAL_W-1:0]     setpoint,
	output logic                               done,
	output logic [stb_pkg::IDX_W-1:0]          report_index,
	output logic                               running,
	output logic                               expired,
	output logic [stb_pkg::VAL_W-1:0]          elapsed,
	output logic [stb_pkg::VAL_W-1:0]          overflow_count,
	output logic [stb_pkg::MASK_W-1:0]         expired_mask
);

	stb_pkg::state_t                  state_q, state_d;
	stb_pkg::cmd_t                    cmd_q;
	logic [stb_pkg::IDX_W-1:0]        idx_q;
	logic [stb_pkg::VAL_W-1:0]        sp_q;
	logic [stb_pkg::AW-1:0]           ptr_q;
	logic [stb_pkg::NUM_TIMERS-1:0]   exp_q;
	logic                             done_q;
	logic                             rpt_en_q, rpt_exp_q;
	logic [stb_pkg::VAL_W-1:0]        rpt_cnt_q, rpt_tot_q;

	stb_pkg::mem_req_t                req;
	stb_pkg::entry_t                  rdata, wentry;
	logic                             accept, valid, last, hit;
	logic                             wr_en, new_exp;
	logic [stb_pkg::VAL_W:0]          cnt_inc;

	stb_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rdata  (rdata)
	);

	assign accept = start && (state_q == stb_pkg::ST_IDLE);
	assign valid  = stb_pkg::CNT_W'(idx_q) < stb_pkg::CNT_W'(stb_pkg::NUM_TIMERS);
	assign last   = (cmd_q != stb_pkg::CMD_TICK) ||
	                (ptr_q == stb_pkg::AW'(stb_pkg::NUM_TIMERS - 1));
	assign hit    = valid && (ptr_q == stb_pkg::AW'(idx_q));
	assign cnt_inc = {1'b0, rdata.count} + {{stb_pkg::VAL_W{1'b0}}, 1'b1};

	// entry update for the entry under the pointer
	always_comb begin
		wentry  = rdata;
		new_exp = exp_q[ptr_q];
		wr_en   = 1'b0;
		unique case (cmd_q)
			stb_pkg::CMD_TICK: begin
				if (rdata.en) begin
					wr_en = 1'b1;
					if (cnt_inc > {1'b0, rdata.limit}) begin
						wentry.count = '0;
						wentry.total = rdata.total + stb_pkg::VAL_W'(1);
						new_exp      = 1'b1;
					end else begin
						wentry.count = cnt_inc[stb_pkg::VAL_W-1:0];
					end
				end
			end
			stb_pkg::CMD_START: begin
				if (valid && !rdata.en) begin
					wr_en        = 1'b1;
					wentry.en    = 1'b1;
					wentry.limit = (sp_q == '0) ? '0 : sp_q - stb_pkg::VAL_W'(1);
					wentry.count = '0;
					new_exp      = 1'b0;
				end
			end
			stb_pkg::CMD_STOP: begin
				if (valid) begin
					wr_en        = 1'b1;
					wentry.en    = 1'b0;
					wentry.limit = '0;
					wentry.count = '0;
					new_exp      = 1'b0;
				end
			end
			stb_pkg::CMD_READ: begin
				wr_en = 1'b0;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			stb_pkg::ST_IDLE: begin
				if (start) state_d = stb_pkg::ST_ISSUE;
			end
			stb_pkg::ST_ISSUE: begin
				state_d = stb_pkg::ST_MOD;
			end
			stb_pkg::ST_MOD: begin
				if (last) state_d = stb_pkg::ST_IDLE;
			end
			default: begin
				state_d = stb_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req       = '0;
		req.wdata = wentry;
		req.waddr = ptr_q;
		req.raddr = ptr_q;
		unique case (state_q)
			stb_pkg::ST_IDLE: begin
				req.re = 1'b0;
			end
			stb_pkg::ST_ISSUE: begin
				req.re = 1'b1;
			end
			stb_pkg::ST_MOD: begin
				req.we = wr_en;
				// next entry of the sweep is read while this one is written
				if (!last) begin
					req.re    = 1'b1;
					req.raddr = ptr_q + stb_pkg::AW'(1);
				end
			end
			default: begin
				req.re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stb_pkg::ST_IDLE;
			done_q  <= 1'b0;
			exp_q   <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == stb_pkg::ST_MOD) && last;
			if (state_q == stb_pkg::ST_MOD) begin
				exp_q[ptr_q] <= new_exp;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= stb_pkg::cmd_t'(command);
			idx_q     <= timer_index;
			sp_q      <= setpoint;
			ptr_q     <= (stb_pkg::cmd_t'(command) == stb_pkg::CMD_TICK) ?
			             '0 : stb_pkg::AW'(timer_index);
			rpt_en_q  <= 1'b0;
			rpt_exp_q <= 1'b0;
			rpt_cnt_q <= '0;
			rpt_tot_q <= '0;
		end else if (state_q == stb_pkg::ST_MOD) begin
			if (!last) begin
				ptr_q <= ptr_q + stb_pkg::AW'(1);
			end
			if (hit) begin
				rpt_en_q  <= wentry.en;
				rpt_exp_q <= new_exp;
				rpt_cnt_q <= wentry.count;
				rpt_tot_q <= wentry.total;
			end
		end
	end

	for (genvar g = 0; g < stb_pkg::MASK_W; g++) begin : g_mask
		if (g < stb_pkg::NUM_TIMERS) begin : g_on
			assign expired_mask[g] = exp_q[g];
		end else begin : g_off
			assign expired_mask[g] = 1'b0;
		end
	end

	assign busy           = (state_q != stb_pkg::ST_IDLE);
	assign done           = done_q;
	assign report_index   = idx_q;
	assign running        = rpt_en_q;
	assign expired        = rpt_exp_q;
	assign elapsed        = rpt_cnt_q;
	assign overflow_count = rpt_tot_q;

endmodule
`default_nettype wire

/* hdl/stb_chk.sv */
// port-level checks for the software timer bank, bound to the top level
`default_nettype none
module stb_chk (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          start,
	input wire logic                          busy,
	input wire logic                          done,
	input wire logic [stb_pkg::IDX_W-1:0]     report_index,
	input wire logic                          running,
	input wire logic                          expired,
	input wire logic [stb_pkg::VAL_W-1:0]     elapsed,
	input wire logic [stb_pkg::MASK_W-1:0]    expired_mask
);

	// a result frees the block for the next transaction
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy high while result shown");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted transaction did not hold busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_mask_agrees: assert property (@(posedge clk) disable iff (!arst_n)
		(done && expired) |-> expired_mask[report_index])
		else $error("expired flag missing from mask");

	// an idle timer always holds a cleared count
	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !running) |-> (elapsed == '0))
		else $error("stopped timer reports nonzero count");

endmodule

bind software_timer_bank_top stb_chk u_stb_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.report_index (report_index),
	.running      (running),
	.expired      (expired),
	.elapsed      (elapsed),
	.expired_mask (expired_mask)
);
`default_nettype wire
